// ===== rtl/core/acsh_pkg.sv =====
// Shared types and constants for the spatial-hash cell address generator.
package acsh_pkg;

   localparam int COORD_W  = 32;
   localparam int SCALE_W  = 32;
   localparam int BUCKET_W = 24;
   localparam int PRIME_W  = 27;
   localparam int AXES     = 3;
   localparam int AXIS_W   = 2;

   // Signed coordinate times zero-extended prime.
   localparam int HASH_W    = COORD_W + PRIME_W + 1;
   localparam int DIV_RADIX = 2;
   localparam int DIV_STEPS = HASH_W / DIV_RADIX;
   localparam int QUANT_OPS = 2 * AXES;
   localparam int STEP_W    = $clog2(DIV_STEPS + 1);

   localparam logic [PRIME_W-1:0] PRIME_X = 27'd73856093;
   localparam logic [PRIME_W-1:0] PRIME_Y = 27'd19349663;
   localparam logic [PRIME_W-1:0] PRIME_Z = 27'd83492791;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SCALE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE = 1'b1;

   localparam logic [SCALE_W-1:0]  CELL_SCALE_RESET = 32'd65536;
   localparam logic [BUCKET_W-1:0] TABLE_SIZE_RESET = 24'd9999;

   typedef struct packed {
      logic              load;
      logic              q_issue;
      logic              q_max;
      logic [AXIS_W-1:0] q_axis;
      logic              span_calc;
      logic              h_issue;
      logic [AXIS_W-1:0] h_axis;
      logic              h_abs;
      logic              div_step;
      logic              walk_next;
   } acsh_cmd_type;

   typedef struct packed {
      logic walk_last;
   } acsh_status_type;

endpackage

// ===== rtl/core/acsh_ctrl.sv =====
// Sequencer for quantizing, box walking, hashing and bucket reduction.
module acsh_ctrl import acsh_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  acsh_status_type status,
   output acsh_cmd_type    cmd,
   output logic            busy,
   output logic            rsp_valid
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_QUANT = 7'b0000010,
      ST_SPAN  = 7'b0000100,
      ST_HMUL  = 7'b0001000,
      ST_HABS  = 7'b0010000,
      ST_DIV   = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_QUANT;
               step_in  = '0;
            end
         end
         ST_QUANT: begin
            // issue min corners then max corners; a final idle step drains the multiplier
            if (step_ff < STEP_W'(QUANT_OPS)) begin
               cmd.q_issue = 1'b1;
               cmd.q_max   = (step_ff >= STEP_W'(AXES));
               cmd.q_axis  = (step_ff >= STEP_W'(AXES)) ? AXIS_W'(step_ff - STEP_W'(AXES))
                                                         : AXIS_W'(step_ff);
            end
            if (step_ff == STEP_W'(QUANT_OPS)) begin
               state_in = ST_SPAN;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_SPAN: begin
            cmd.span_calc = 1'b1;
            state_in      = ST_HMUL;
            step_in       = '0;
         end
         ST_HMUL: begin
            if (step_ff < STEP_W'(AXES)) begin
               cmd.h_issue = 1'b1;
               cmd.h_axis  = AXIS_W'(step_ff);
            end
            if (step_ff == STEP_W'(AXES)) begin
               state_in = ST_HABS;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_HABS: begin
            cmd.h_abs = 1'b1;
            state_in  = ST_DIV;
            step_in   = '0;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_EMIT: begin
            if (status.walk_last) begin
               state_in = ST_IDLE;
            end else begin
               cmd.walk_next = 1'b1;
               state_in      = ST_HMUL;
               step_in       = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

endmodule

// ===== rtl/core/acsh_datapath.sv =====
// Datapath: box corners, quantizer, cell walk counters, hash multiplier and bucket divider.
module acsh_datapath import acsh_pkg::*; #(
   parameter int MAX_SPAN = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata,
   input  logic                        req_mode,
   input  logic signed [COORD_W-1:0]   req_ax,
   input  logic signed [COORD_W-1:0]   req_ay,
   input  logic signed [COORD_W-1:0]   req_az,
   input  logic signed [COORD_W-1:0]   req_bx,
   input  logic signed [COORD_W-1:0]   req_by_coord,
   input  logic signed [COORD_W-1:0]   req_bz,
   input  logic signed [COORD_W-1:0]   req_cx,
   input  logic signed [COORD_W-1:0]   req_cy,
   input  logic signed [COORD_W-1:0]   req_cz,
   input  acsh_cmd_type                cmd,
   output acsh_status_type             status,
   output logic [BUCKET_W-1:0]         rsp_bucket,
   output logic                        rsp_last,
   output logic                        rsp_span_clamped
);

   localparam int SPAN_W = $clog2(MAX_SPAN + 1);
   localparam int PROD_W = COORD_W + SCALE_W;

   function automatic logic signed [COORD_W-1:0] pick(input logic signed [COORD_W-1:0] v0,
                                                       input logic signed [COORD_W-1:0] v1,
                                                       input logic signed [COORD_W-1:0] v2,
                                                       input logic [AXIS_W-1:0]         sel);
      logic signed [COORD_W-1:0] r;
      case (sel)
         2'd0:    r = v0;
         2'd1:    r = v1;
         default: r = v2;
      endcase
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] min3(input logic signed [COORD_W-1:0] a,
                                                       input logic signed [COORD_W-1:0] b,
                                                       input logic signed [COORD_W-1:0] c);
      logic signed [COORD_W-1:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic logic signed [COORD_W-1:0] max3(input logic signed [COORD_W-1:0] a,
                                                       input logic signed [COORD_W-1:0] b,
                                                       input logic signed [COORD_W-1:0] c);
      logic signed [COORD_W-1:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   // configuration
   logic [SCALE_W-1:0]  cell_scale_ff;
   logic [BUCKET_W-1:0] table_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_scale_ff <= CELL_SCALE_RESET;
         table_size_ff <= TABLE_SIZE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CELL_SCALE: cell_scale_ff <= SCALE_W'(csr_wdata);
            CSR_TABLE_SIZE: table_size_ff <= BUCKET_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   // box corners; a point is a box of one vertex
   logic signed [COORD_W-1:0] va [AXES];
   logic signed [COORD_W-1:0] vb [AXES];
   logic signed [COORD_W-1:0] vc [AXES];
   logic signed [COORD_W-1:0] cmin_ff [AXES];
   logic signed [COORD_W-1:0] cmax_ff [AXES];

   assign va[0] = req_ax;
   assign va[1] = req_ay;
   assign va[2] = req_az;
   assign vb[0] = req_bx;
   assign vb[1] = req_by_coord;
   assign vb[2] = req_bz;
   assign vc[0] = req_cx;
   assign vc[1] = req_cy;
   assign vc[2] = req_cz;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int a = 0; a < AXES; a++) begin
            cmin_ff[a] <= req_mode ? min3(va[a], vb[a], vc[a]) : va[a];
            cmax_ff[a] <= req_mode ? max3(va[a], vb[a], vc[a]) : va[a];
         end
      end
   end

   // quantizer: magnitude times scale, keep integer part, restore sign
   logic signed [COORD_W-1:0] q_op;
   logic [COORD_W-1:0]        q_mag;
   logic [PROD_W-1:0]         q_prod_ff;
   logic                      q_neg_ff;
   logic                      q_max_ff;
   logic [AXIS_W-1:0]         q_axis_ff;
   logic                      q_valid_ff;
   logic [COORD_W-1:0]        q_int;
   logic signed [COORD_W-1:0] q_res;
   logic signed [COORD_W-1:0] lo_ff [AXES];
   logic signed [COORD_W-1:0] hi_ff [AXES];

   assign q_op  = cmd.q_max ? pick(cmax_ff[0], cmax_ff[1], cmax_ff[2], cmd.q_axis)
                            : pick(cmin_ff[0], cmin_ff[1], cmin_ff[2], cmd.q_axis);
   assign q_mag = q_op[COORD_W-1] ? COORD_W'(-q_op) : COORD_W'(q_op);
   assign q_int = q_prod_ff[PROD_W-1:SCALE_W];
   assign q_res = q_neg_ff ? $signed(COORD_W'(-q_int)) : $signed(q_int);

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else begin
         q_valid_ff <= cmd.q_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.q_issue) begin
         q_prod_ff <= PROD_W'(q_mag) * PROD_W'(cell_scale_ff);
         q_neg_ff  <= q_op[COORD_W-1];
         q_max_ff  <= cmd.q_max;
         q_axis_ff <= cmd.q_axis;
      end
      if (q_valid_ff) begin
         for (int a = 0; a < AXES; a++) begin
            if (q_axis_ff == AXIS_W'(a)) begin
               if (q_max_ff) begin
                  hi_ff[a] <= q_res;
               end else begin
                  lo_ff[a] <= q_res;
               end
            end
         end
      end
   end

   // span clamp and cell walk, z innermost
   logic signed [COORD_W:0]   span_diff [AXES];
   logic [AXES-1:0]           span_big;
   logic [SPAN_W-1:0]         n_ff   [AXES];
   logic [SPAN_W-1:0]         cnt_ff [AXES];
   logic signed [COORD_W-1:0] cur_ff [AXES];
   logic                      clamp_ff;
   logic [AXES-1:0]           wrap;
   logic [AXES-1:0]           advance;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         span_diff[a] = {hi_ff[a][COORD_W-1], hi_ff[a]} - {lo_ff[a][COORD_W-1], lo_ff[a]};
         span_big[a]  = (span_diff[a] >= $signed((COORD_W + 1)'(MAX_SPAN)));
         wrap[a]      = (cnt_ff[a] == SPAN_W'(n_ff[a] - SPAN_W'(1)));
      end
      advance[2] = 1'b1;
      advance[1] = wrap[2];
      advance[0] = wrap[2] & wrap[1];
   end

   assign status.walk_last = &wrap;

   always_ff @(posedge clock) begin
      if (cmd.span_calc) begin
         for (int a = 0; a < AXES; a++) begin
            n_ff[a]   <= span_big[a] ? SPAN_W'(MAX_SPAN)
                                     : SPAN_W'(span_diff[a][SPAN_W-1:0] + SPAN_W'(1));
            cnt_ff[a] <= '0;
            cur_ff[a] <= lo_ff[a];
         end
         clamp_ff <= |span_big;
      end else if (cmd.walk_next) begin
         for (int a = 0; a < AXES; a++) begin
            if (advance[a]) begin
               if (wrap[a]) begin
                  cnt_ff[a] <= '0;
                  cur_ff[a] <= lo_ff[a];
               end else begin
                  cnt_ff[a] <= cnt_ff[a] + SPAN_W'(1);
                  cur_ff[a] <= cur_ff[a] + COORD_W'(1);
               end
            end
         end
      end
   end

   // hash: one axis product per cycle, folded by xor
   logic signed [COORD_W-1:0] h_op;
   logic [PRIME_W-1:0]        h_prime;
   logic signed [HASH_W-1:0]  h_prod_in;
   logic signed [HASH_W-1:0]  h_prod_ff;
   logic                      h_valid_ff;
   logic                      h_first_ff;
   logic signed [HASH_W-1:0]  acc_ff;

   assign h_op = pick(cur_ff[0], cur_ff[1], cur_ff[2], cmd.h_axis);

   always_comb begin
      case (cmd.h_axis)
         2'd0:    h_prime = PRIME_X;
         2'd1:    h_prime = PRIME_Y;
         default: h_prime = PRIME_Z;
      endcase
   end

   assign h_prod_in = h_op * $signed({1'b0, h_prime});

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else begin
         h_valid_ff <= cmd.h_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.h_issue) begin
         h_prod_ff  <= h_prod_in;
         h_first_ff <= (cmd.h_axis == '0);
      end
      if (h_valid_ff) begin
         acc_ff <= h_first_ff ? h_prod_ff : (acc_ff ^ h_prod_ff);
      end
   end

   // restoring remainder, DIV_RADIX dividend bits per cycle
   logic [HASH_W-1:0]   dvd_ff, dvd_in;
   logic [BUCKET_W-1:0] rem_ff, rem_in;
   logic [BUCKET_W:0]   trial;

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      trial  = '0;
      for (int s = 0; s < DIV_RADIX; s++) begin
         trial  = {rem_in, dvd_in[HASH_W-1]};
         dvd_in = {dvd_in[HASH_W-2:0], 1'b0};
         if (trial >= {1'b0, table_size_ff}) begin
            rem_in = BUCKET_W'(trial - {1'b0, table_size_ff});
         end else begin
            rem_in = trial[BUCKET_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.h_abs) begin
         dvd_ff <= acc_ff[HASH_W-1] ? HASH_W'(-acc_ff) : HASH_W'(acc_ff);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   assign rsp_bucket       = (table_size_ff == '0) ? '0 : rem_ff;
   assign rsp_last         = status.walk_last;
   assign rsp_span_clamped = clamp_ff;

endmodule

// ===== rtl/core/aabb_cell_spatial_hasher_core.sv =====
// Top level of the spatial-hash cell address generator.
// Each item is quantized once; each cell it walks then goes through the shared hash
// multiplier, the sign fold and the 2-bit-per-cycle remainder unit before its result is
// presented. A new item is taken only when idle; cells per item range from 1 to MAX_SPAN
// cubed, and busy stays high until the last result.
// Reset returns the sequencer to idle and loads the default scale and table size.
module aabb_cell_spatial_hasher_core import acsh_pkg::*; #(
   parameter int MAX_SPAN = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_mode,
   input  logic signed [COORD_W-1:0] req_ax,
   input  logic signed [COORD_W-1:0] req_ay,
   input  logic signed [COORD_W-1:0] req_az,
   input  logic signed [COORD_W-1:0] req_bx,
   input  logic signed [COORD_W-1:0] req_by_coord,
   input  logic signed [COORD_W-1:0] req_bz,
   input  logic signed [COORD_W-1:0] req_cx,
   input  logic signed [COORD_W-1:0] req_cy,
   input  logic signed [COORD_W-1:0] req_cz,
   output logic                      rsp_valid,
   output logic [BUCKET_W-1:0]       rsp_bucket,
   output logic                      rsp_last,
   output logic                      rsp_span_clamped,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   acsh_cmd_type    cmd;
   acsh_status_type status;

   acsh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   acsh_datapath #(
      .MAX_SPAN (MAX_SPAN)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_mode         (req_mode),
      .req_ax           (req_ax),
      .req_ay           (req_ay),
      .req_az           (req_az),
      .req_bx           (req_bx),
      .req_by_coord     (req_by_coord),
      .req_bz           (req_bz),
      .req_cx           (req_cx),
      .req_cy           (req_cy),
      .req_cz           (req_cz),
      .cmd              (cmd),
      .status           (status),
      .rsp_bucket       (rsp_bucket),
      .rsp_last         (rsp_last),
      .rsp_span_clamped (rsp_span_clamped)
   );

endmodule

// ===== rtl/core/acsh_checker.sv =====
// Port-level checks for the spatial-hash core, bound to the top level.
module acsh_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_last
);

   a_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown while idle");

   a_start_takes_item: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !busy)
      else $error("busy held after last result");

   a_more_cells_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> busy && !rsp_valid)
      else $error("walk ended early or results back to back");

endmodule

bind aabb_cell_spatial_hasher_core acsh_checker u_acsh_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_last  (rsp_last)
);

// ===== bench/aabb_cell_spatial_hasher_core_tb.sv =====
// Self-checking testbench for the spatial-hash cell address generator core.
module aabb_cell_spatial_hasher_core_tb import acsh_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SPAN = 4;
   localparam int ONE_CELL = 65536;
   localparam int POS_MAX  = 32'h7FFF_FFFF;
   localparam int POS_MIN  = 32'h8000_0000;
   localparam logic MODE_POINT = 1'b0;
   localparam logic MODE_BOX   = 1'b1;

   typedef struct packed {
      logic                     mode;
      logic [8:0][COORD_W-1:0] pos;
   } hash_item_type;

   typedef struct packed {
      logic [BUCKET_W-1:0] bucket;
      logic                last;
      logic                clamped;
   } cell_result_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_mode;
   logic signed [COORD_W-1:0] req_ax, req_ay, req_az;
   logic signed [COORD_W-1:0] req_bx, req_by_coord, req_bz;
   logic signed [COORD_W-1:0] req_cx, req_cy, req_cz;
   logic                      rsp_valid;
   logic [BUCKET_W-1:0]       rsp_bucket;
   logic                      rsp_last;
   logic                      rsp_span_clamped;
   logic                      csr_we;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]     csr_wdata;

   cell_result_type     pending_cells[$];
   cell_result_type     got_cell, want_cell;
   logic [SCALE_W-1:0]  model_scale;
   logic [BUCKET_W-1:0] model_table;
   logic                pacing;
   int fail_count, items_sent, point_items, box_items, clamped_items;
   int cells_checked, settings_used;

   aabb_cell_spatial_hasher_core #(
      .MAX_SPAN(MAX_SPAN)
   ) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode),
      .req_ax(req_ax), .req_ay(req_ay), .req_az(req_az),
      .req_bx(req_bx), .req_by_coord(req_by_coord), .req_bz(req_bz),
      .req_cx(req_cx), .req_cy(req_cy), .req_cz(req_cz),
      .rsp_valid(rsp_valid), .rsp_bucket(rsp_bucket), .rsp_last(rsp_last),
      .rsp_span_clamped(rsp_span_clamped),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #60_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Cell index: magnitude times scale, truncated, sign put back afterwards.
   function automatic longint cell_index(logic signed [COORD_W-1:0] coord);
      longint     sc;
      logic [63:0] mag, q;
      sc  = coord;
      mag = (sc < 0) ? -sc : sc;
      q   = (mag * 64'(model_scale)) >> 32;
      return (sc < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [BUCKET_W-1:0] cell_bucket(longint i, longint j, longint k);
      logic [63:0] ui, uj, uk, t;
      ui = i;
      uj = j;
      uk = k;
      t  = (ui * 64'(PRIME_X)) ^ (uj * 64'(PRIME_Y)) ^ (uk * 64'(PRIME_Z));
      if (t[63])
         t = -t;
      if (model_table == 0)
         return '0;
      t = t % 64'(model_table);
      return t[BUCKET_W-1:0];
   endfunction

   function automatic hash_item_type make_item(logic mode, int p0, int p1, int p2, int p3,
                                               int p4, int p5, int p6, int p7, int p8);
      hash_item_type it;
      it.mode = mode;
      it.pos  = {p8, p7, p6, p5, p4, p3, p2, p1, p0};
      return it;
   endfunction

   task automatic log_failure(string what);
      fail_count++;
      if (fail_count <= 10)
         $display("[%0t] %s", $realtime, what);
   endtask

   // Work out every cell bucket the item walks and queue them in walk order.
   task automatic queue_cells(hash_item_type it);
      longint lo[3], n[3];
      longint mn, mx, total, count, i, j, k;
      logic signed [COORD_W-1:0] p, q, r, smin, smax;
      logic clamp;
      cell_result_type c;
      items_sent++;
      if (it.mode == MODE_POINT) begin
         point_items++;
         c.bucket  = cell_bucket(cell_index(it.pos[0]), cell_index(it.pos[1]),
                                 cell_index(it.pos[2]));
         c.last    = 1'b1;
         c.clamped = 1'b0;
         pending_cells = {pending_cells, c};
         return;
      end
      box_items++;
      clamp = 1'b0;
      for (int a = 0; a < 3; a++) begin
         p = it.pos[a];
         q = it.pos[a + 3];
         r = it.pos[a + 6];
         smin = p;
         smax = p;
         if (q < smin) smin = q;
         if (r < smin) smin = r;
         if (q > smax) smax = q;
         if (r > smax) smax = r;
         mn = cell_index(smin);
         mx = cell_index(smax);
         lo[a] = mn;
         n[a]  = mx - mn + 1;
         if (n[a] > MAX_SPAN) begin
            n[a]  = MAX_SPAN;
            clamp = 1'b1;
         end
      end
      if (clamp)
         clamped_items++;
      total = n[0] * n[1] * n[2];
      count = 0;
      for (i = 0; i < n[0]; i++)
         for (j = 0; j < n[1]; j++)
            for (k = 0; k < n[2]; k++) begin
               c.bucket  = cell_bucket(lo[0] + i, lo[1] + j, lo[2] + k);
               c.last    = (count + 1 == total);
               c.clamped = clamp;
               pending_cells = {pending_cells, c};
               count++;
            end
   endtask

   // Hold start until the item is taken; leave it high so back-to-back items need no drop.
   task automatic send_item(hash_item_type it);
      req_mode     <= it.mode;
      req_ax       <= it.pos[0];
      req_ay       <= it.pos[1];
      req_az       <= it.pos[2];
      req_bx       <= it.pos[3];
      req_by_coord <= it.pos[4];
      req_bz       <= it.pos[5];
      req_cx       <= it.pos[6];
      req_cy       <= it.pos[7];
      req_cz       <= it.pos[8];
      start        <= 1'b1;
      do
         @(posedge clock);
      while (busy);
      queue_cells(it);
   endtask

   task automatic pace();
      if (pacing && $urandom_range(99) < 38) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 60)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do
         @(posedge clock);
      while (pending_cells.size() != 0 || busy);
      repeat (3) @(posedge clock);
   endtask

   task automatic apply_settings(logic [SCALE_W-1:0] scale, logic [BUCKET_W-1:0] buckets);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_CELL_SCALE;
      csr_wdata <= scale;
      @(posedge clock);
      // upper byte of the table size write is junk and must be ignored
      csr_index <= CSR_TABLE_SIZE;
      csr_wdata <= {8'($urandom), buckets};
      @(posedge clock);
      csr_we      <= 1'b0;
      model_scale = scale;
      model_table = buckets;
      settings_used++;
   endtask

   task automatic run_list(hash_item_type items[$]);
      foreach (items[n]) begin
         pace();
         send_item(items[n]);
      end
   endtask

   task automatic test_defaults();
      hash_item_type items[$];
      items = {items, make_item(MODE_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
      items = {items, make_item(MODE_POINT, POS_MAX, POS_MAX, POS_MAX,
                                POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MIN, POS_MAX)};
      items = {items, make_item(MODE_POINT, POS_MIN, POS_MIN, POS_MIN, 0, 0, 0, 0, 0, 0)};
      items = {items, make_item(MODE_POINT, -1, -1, -1, POS_MAX, -1, POS_MIN, 1, 1, 1)};
      items = {items, make_item(MODE_BOX, 3 * ONE_CELL + 5, -7 * ONE_CELL, 123456,
                                3 * ONE_CELL + 5, -7 * ONE_CELL, 123456,
                                3 * ONE_CELL + 5, -7 * ONE_CELL, 123456)};
      // straddle zero: truncation toward zero makes cell 0 twice as wide
      items = {items, make_item(MODE_BOX, -98304, -32768, 32768, 32768, 98304, -98304,
                                0, 0, 0)};
      items = {items, make_item(MODE_BOX, 0, 0, 0, 229376, 229376, 229376,
                                ONE_CELL, ONE_CELL, ONE_CELL)};
      items = {items, make_item(MODE_BOX, 0, 0, 0, 5 * ONE_CELL, ONE_CELL, 0,
                                ONE_CELL, 0, 0)};
      items = {items, make_item(MODE_BOX, POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX,
                                POS_MAX, 0, 0, 0)};
      items = {items, make_item(MODE_BOX, POS_MAX, POS_MIN, 0, POS_MAX - ONE_CELL,
                                POS_MIN + ONE_CELL, -1, POS_MAX - 5, POS_MIN + 9, 1)};
      run_list(items);
   endtask

   task automatic test_zero_table();
      hash_item_type items[$];
      apply_settings(32'd65536, 24'd0);
      items = {items, make_item(MODE_POINT, 12345678, -87654321, 5555, 0, 0, 0, 0, 0, 0)};
      items = {items, make_item(MODE_BOX, -98304, -32768, 32768, 32768, 98304, -98304,
                                0, 0, 0)};
      run_list(items);
   endtask

   task automatic test_zero_scale();
      hash_item_type items[$];
      apply_settings(32'd0, 24'hFF_FFFF);
      items = {items, make_item(MODE_POINT, POS_MAX, POS_MIN, -1, 0, 0, 0, 0, 0, 0)};
      items = {items, make_item(MODE_BOX, POS_MIN, POS_MAX, POS_MIN, POS_MAX, POS_MIN,
                                POS_MAX, 0, 0, 0)};
      run_list(items);
   endtask

   task automatic test_full_scale();
      hash_item_type items[$];
      apply_settings(32'hFFFF_FFFF, 24'hFF_FFFF);
      items = {items, make_item(MODE_POINT, POS_MAX, POS_MAX, POS_MAX, 0, 0, 0, 0, 0, 0)};
      items = {items, make_item(MODE_POINT, POS_MIN, POS_MIN, POS_MIN, 0, 0, 0, 0, 0, 0)};
      items = {items, make_item(MODE_BOX, 100, 100, 100, 102, 101, 100, 101, 103, 99)};
      items = {items, make_item(MODE_BOX, -3, 7, -200, 2, 8, -190, 0, 7, -195)};
      run_list(items);
   endtask

   task automatic test_min_scale();
      hash_item_type items[$];
      apply_settings(32'd1, 24'd7);
      items = {items, make_item(MODE_POINT, POS_MAX, POS_MIN, POS_MAX, 0, 0, 0, 0, 0, 0)};
      items = {items, make_item(MODE_BOX, POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX,
                                POS_MAX, -1, 1, 0)};
      run_list(items);
   endtask

   // Mostly small boxes near a random origin; the rest points and unbounded junk.
   task automatic test_random_phases();
      logic [SCALE_W-1:0]  scales[5];
      logic [BUCKET_W-1:0] tables[5];
      logic [63:0]         reach;
      int                  origin[3];
      int                  pick;
      hash_item_type       it;
      scales = '{32'd65536, 32'd262144, 32'd16384, 32'($urandom), 32'hFFFF_FFFF};
      tables = '{24'd9999, 24'd1023, 24'hFF_FFFF, 24'($urandom_range(1, 24'hFF_FFFF)),
                 24'($urandom_range(1, 24'hFF_FFFF))};
      if (scales[3] == 0)
         scales[3] = 32'd1;
      for (int ph = 0; ph < 5; ph++) begin
         apply_settings(scales[ph], tables[ph]);
         pacing = (ph != 1);
         reach = (64'd5 << 32) / model_scale;
         if (reach > 64'd1 << 30)
            reach = 64'd1 << 30;
         for (int n = 0; n < 50; n++) begin
            pick = $urandom_range(99);
            it.mode = (pick >= 20);
            for (int v = 0; v < 9; v++)
               it.pos[v] = $urandom;
            if (pick >= 20 && pick < 85) begin
               for (int a = 0; a < 3; a++)
                  origin[a] = $signed($urandom) >>> 1;
               for (int v = 0; v < 9; v++)
                  it.pos[v] = origin[v % 3] + int'($urandom_range(0, 32'(reach)));
            end
            pace();
            send_item(it);
         end
      end
      pacing = 1'b1;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         got_cell = '{rsp_bucket, rsp_last, rsp_span_clamped};
         if (pending_cells.size() == 0) begin
            log_failure($sformatf("unexpected result: bucket %0d last %0b clamped %0b",
                                  got_cell.bucket, got_cell.last, got_cell.clamped));
         end else begin
            want_cell = pending_cells.pop_front();
            cells_checked++;
            if (got_cell.bucket !== want_cell.bucket || got_cell.last !== want_cell.last ||
                got_cell.clamped !== want_cell.clamped)
               log_failure($sformatf(
                  "mismatch: expected bucket %0d last %0b clamped %0b, got %0d %0b %0b",
                  want_cell.bucket, want_cell.last, want_cell.clamped,
                  got_cell.bucket, got_cell.last, got_cell.clamped));
         end
      end
   end

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_mode     = 1'b0;
      req_ax       = '0;
      req_ay       = '0;
      req_az       = '0;
      req_bx       = '0;
      req_by_coord = '0;
      req_bz       = '0;
      req_cx       = '0;
      req_cy       = '0;
      req_cz       = '0;
      csr_we       = 1'b0;
      csr_index    = CSR_CELL_SCALE;
      csr_wdata    = '0;
      pacing       = 1'b1;
      model_scale  = CELL_SCALE_RESET;
      model_table  = TABLE_SIZE_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_defaults();
      test_zero_table();
      test_zero_scale();
      test_full_scale();
      test_min_scale();
      test_random_phases();

      wait_idle();
      repeat (50) @(posedge clock);
      if (pending_cells.size() != 0)
         log_failure($sformatf("%0d results never arrived", pending_cells.size()));

      $display("Sent %0d items (%0d points, %0d boxes, %0d boxes span-clamped)",
               items_sent, point_items, box_items, clamped_items);
      $display("Checked %0d cell buckets over %0d register settings, %0d failures",
               cells_checked, settings_used + 1, fail_count);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
